// ----- design/prb_pkg.sv -----
// ----------------------------------------------------------------------------
// prb_pkg
// Shared types, command codes and result builders for the per-channel replay
// buffer.
// ----------------------------------------------------------------------------
package prb_pkg;

  localparam int CAP_W = 7;

  localparam logic [1:0] CMD_STORE  = 2'd0;
  localparam logic [1:0] CMD_REPLAY = 2'd1;
  localparam logic [1:0] CMD_NEXT   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  channel;
    logic [31:0] seq_in;
    logic [31:0] payload_in;
    logic        reliable;
    logic [31:0] acked_seq;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] out_seq;
    logic [31:0] out_payload;
    logic        last;
    logic        replay_ok;
    logic        resync_req;
    logic [31:0] issued_seq;
  } out_item_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] payload;
  } entry_t;

  // Result that carries one replayed entry.
  function automatic out_item_t res_entry(entry_t e, logic is_last);
    out_item_t r;
    r.entry_valid = 1'b1;
    r.out_seq     = e.seq;
    r.out_payload = e.payload;
    r.last        = is_last;
    r.replay_ok   = 1'b1;
    r.resync_req  = 1'b0;
    r.issued_seq  = '0;
    return r;
  endfunction

  // Single closing result without an entry.
  function automatic out_item_t res_flag(logic ok, logic need, logic [31:0] issued);
    out_item_t r;
    r.entry_valid = 1'b0;
    r.out_seq     = '0;
    r.out_payload = '0;
    r.last        = 1'b1;
    r.replay_ok   = ok;
    r.resync_req  = need;
    r.issued_seq  = issued;
    return r;
  endfunction

endpackage

// ----- design/per_channel_replay_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// per_channel_replay_buffer_unit
// Per-channel bounded FIFOs of reliable entries with sequence counters,
// replayed past an acknowledged sequence.
// ----------------------------------------------------------------------------
//   channel  handshake           payload      role
//   cfg_     cfg_valid/ready     cfg_data     entry_cap write
//   in_      in_valid/ready      in_item_t    command in
//   out_     out_valid/ready     out_item_t   result out
//
// Store and clear pass from the transfer through S_META (meta read at the
// transfer, read-modify-write) back to idle; next sequence passes through S_META
// and S_EMIT, which loads its result. Replay on an empty channel goes S_META,
// S_EMIT; with a gap S_META, S_FRONT, S_EMIT; a walk adds S_WALK, one entry read per cycle.
// A stalled output holds the walk and the final load in place.
// No clearing pass after reset: per-channel valid bits make unwritten
// channels read as empty. cfg_ready is always high.
// ----------------------------------------------------------------------------
module per_channel_replay_buffer_unit
  import prb_pkg::*;
#(
  parameter int CHANNELS = 16,
  parameter int DEPTH    = 64,
  parameter int SEQ_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int CHW  = $clog2(CHANNELS);
  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int AW   = CHW + PW;
  localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);
  localparam logic [7:0]       DEPTH8    = 8'(DEPTH);
  localparam logic [PW-1:0]    POS_MAX   = PW'(DEPTH - 1);

  typedef struct packed {
    logic [SEQ_BITS-1:0] ctr;
    logic [CNTW-1:0]     cnt;
    logic [PW-1:0]       head;
  } meta_t;

  typedef enum logic [2:0] {S_IDLE, S_META, S_FRONT, S_WALK, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r;
  logic [CHW-1:0]   ch_r;
  logic             inr_r;
  logic [CAP_W-1:0] cap_r;
  logic [CHANNELS-1:0] mvld_r;
  logic             mvld_rd_r;
  meta_t            meta_rd_r;
  meta_t            meta_mem [CHANNELS];
  logic [PW-1:0]    pos_r, i_r, last_i_r;
  logic             hold_v_r;
  entry_t           hold_r;
  out_item_t        res_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  // input channel decode
  logic [11:0]    in_ch_wide;
  logic           in_inr;
  logic [CHW-1:0] in_ch;
  logic           in_fire;

  assign in_ch_wide = 12'(in_data.channel);
  assign in_inr     = in_ch_wide < 12'(CHANNELS);
  assign in_ch      = in_inr ? in_ch_wide[CHW-1:0] : '0;
  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_ready  = 1'b1;

  // sequence values masked to SEQ_BITS
  logic [63:0]         seq_full, ack_full, seq_m, ack_m, ctr_inc_w;
  logic [SEQ_BITS-1:0] seq_c, ack_c, ctr_inc;
  logic [31:0]         seq32, ack32;

  assign seq_full = 64'(item_r.seq_in);
  assign ack_full = 64'(item_r.acked_seq);
  assign seq_c    = seq_full[SEQ_BITS-1:0];
  assign ack_c    = ack_full[SEQ_BITS-1:0];
  assign seq_m    = 64'(seq_c);
  assign ack_m    = 64'(ack_c);
  assign seq32    = seq_m[31:0];
  assign ack32    = ack_m[31:0];

  // metadata of the current channel; unwritten channels read as zero
  meta_t            m;
  logic [CAP_W-1:0] cnt7, drop7, cnt2_7;
  logic             full;
  logic [7:0]       hsum8, head2_8, psum8, pos8;
  meta_t            m_store;

  assign m     = mvld_rd_r ? meta_rd_r : '0;
  assign cnt7  = CAP_W'(m.cnt);
  assign full  = cnt7 >= cap_r;
  assign drop7 = cnt7 - cap_r + CAP_W'(1);
  assign hsum8 = 8'(m.head) + (full ? 8'(drop7) : 8'd0);
  assign head2_8 = (hsum8 >= DEPTH8) ? hsum8 - DEPTH8 : hsum8;
  assign cnt2_7  = full ? cap_r - CAP_W'(1) : cnt7;
  assign psum8   = head2_8 + 8'(cnt2_7);
  assign pos8    = (psum8 >= DEPTH8) ? psum8 - DEPTH8 : psum8;

  assign ctr_inc   = m.ctr + SEQ_BITS'(1);
  assign ctr_inc_w = 64'(ctr_inc);

  always_comb begin
    m_store.head = head2_8[PW-1:0];
    m_store.cnt  = CNTW'(cnt2_7 + CAP_W'(1));
    m_store.ctr  = (seq_c >= m.ctr) ? seq_c : m.ctr;
  end

  // entry memory
  entry_t         ram_rd, ram_wd;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;

  // walk control
  logic          match, push, out_free, stall, walk_end;
  logic [PW-1:0] pos_next;
  logic          gap;
  logic          out_load;
  out_item_t     out_load_data;

  assign match    = ram_rd.seq > ack32;
  assign push     = match && hold_v_r;
  assign out_free = !out_valid_r || out_ready;
  assign stall    = push && !out_free;
  assign walk_end = (i_r == last_i_r);
  assign pos_next = (pos_r == POS_MAX) ? '0 : pos_r + PW'(1);
  assign gap      = (ram_rd.seq != 32'd0) && (ack32 < ram_rd.seq - 32'd1);

  assign out_load = ((state_r == S_WALK) && push && out_free) ||
                    ((state_r == S_EMIT) && out_free);
  assign out_load_data = (state_r == S_EMIT) ? res_r : res_entry(hold_r, 1'b0);

  assign ram_we    = (state_r == S_META) && (item_r.cmd == CMD_STORE) && inr_r &&
                     (item_r.channel != 4'd0) && item_r.reliable;
  assign ram_waddr = {ch_r, pos8[PW-1:0]};
  assign ram_wd    = '{seq: seq32, payload: item_r.payload_in};

  always_comb begin
    if (state_r == S_META) begin
      ram_raddr = {ch_r, m.head};
    end else if ((state_r == S_WALK) && !stall && !walk_end) begin
      ram_raddr = {ch_r, pos_next};
    end else begin
      ram_raddr = {ch_r, pos_r};
    end
  end

  prb_entry_ram #(
    .AW (AW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wd),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd)
  );

  // metadata write-back
  logic  meta_we;
  meta_t meta_wd;

  always_comb begin
    meta_we = 1'b0;
    meta_wd = m;
    if ((state_r == S_META) && inr_r) begin
      case (item_r.cmd)
        CMD_STORE: begin
          meta_we = ram_we;
          meta_wd = m_store;
        end
        CMD_NEXT: begin
          meta_we     = 1'b1;
          meta_wd.ctr = ctr_inc;
        end
        CMD_CLEAR: begin
          meta_we = 1'b1;
          meta_wd = '0;
        end
        default: begin
          meta_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[ch_r] <= meta_wd;
    end
    if (in_fire) begin
      meta_rd_r <= meta_mem[in_ch];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_META;
      S_META: begin
        unique case (item_r.cmd)
          CMD_STORE, CMD_CLEAR: state_nxt = S_IDLE;
          CMD_NEXT:             state_nxt = S_EMIT;
          CMD_REPLAY: begin
            if (!inr_r || (m.cnt == '0)) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_FRONT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FRONT: state_nxt = gap ? S_EMIT : S_WALK;
      S_WALK:  if (!stall && walk_end) state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= DEPTH_CAP;
      mvld_r      <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // cap writes: ignore zero, saturate at DEPTH
      if (cfg_valid && cfg_ready && (cfg_data != '0)) begin
        cap_r <= (cfg_data > DEPTH_CAP) ? DEPTH_CAP : cfg_data;
      end
      if (meta_we) begin
        mvld_r[ch_r] <= 1'b1;
      end
      if (state_r == S_META) begin
        hold_v_r <= 1'b0;
      end else if ((state_r == S_WALK) && !stall && match) begin
        hold_v_r <= 1'b1;
      end
    end

    if (in_fire) begin
      item_r    <= in_data;
      ch_r      <= in_ch;
      inr_r     <= in_inr;
      mvld_rd_r <= mvld_r[in_ch];
    end

    if (out_load) begin
      out_data_r <= out_load_data;
    end

    unique case (state_r)
      S_META: begin
        pos_r    <= m.head;
        i_r      <= '0;
        last_i_r <= PW'(m.cnt - CNTW'(1));
        if (item_r.cmd == CMD_NEXT) begin
          res_r <= res_flag(1'b0, 1'b0, inr_r ? ctr_inc_w[31:0] : 32'd0);
        end else if (ack32 == 32'd0) begin
          res_r <= res_flag(1'b1, 1'b0, 32'd0);
        end else begin
          res_r <= res_flag(1'b0, 1'b1, 32'd0);
        end
      end
      S_FRONT: begin
        res_r <= res_flag(1'b0, 1'b1, 32'd0);
      end
      S_WALK: begin
        if (!stall) begin
          if (match) begin
            hold_r <= ram_rd;
          end
          if (walk_end) begin
            // close the run with the newest match, or report nothing newer
            if (match) begin
              res_r <= res_entry(ram_rd, 1'b1);
            end else if (hold_v_r) begin
              res_r <= res_entry(hold_r, 1'b1);
            end else begin
              res_r <= res_flag(1'b1, 1'b0, 32'd0);
            end
          end else begin
            i_r   <= i_r + PW'(1);
            pos_r <= pos_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while holding an untaken result");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (i_r <= last_i_r))
    else $error("walk index ran past the stored entry count");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= DEPTH_CAP))
    else $error("entry cap out of range");

  a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRONT) |-> !hold_v_r)
    else $error("held entry left over from an earlier replay");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && !stall && walk_end |=> (state_r == S_EMIT))
    else $error("walk did not close with a final result");

endmodule

// ----- design/prb_entry_ram.sv -----
// ----------------------------------------------------------------------------
// prb_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prb_entry_ram
  import prb_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_channel_replay_buffer_unit. Commands go in over
// the input channel with random gaps while the result channel stalls at
// random. A behavioral copy of the per-channel rings, counters and entry cap
// predicts every result. Directed checks cover the corner cases; seeded
// random traffic in several cap settings then exercises the rest.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prb_pkg::*;

  localparam int CHANNELS    = 16;
  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_LIMIT = 20_000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  // Behavioral state of the buffer
  logic [31:0]      ring_seq [CHANNELS][DEPTH];
  logic [31:0]      ring_pay [CHANNELS][DEPTH];
  logic [5:0]       oldest   [CHANNELS];
  logic [6:0]       fill     [CHANNELS];
  logic [31:0]      chan_seq [CHANNELS];
  logic [6:0]       keep_limit;

  out_item_t        results_due[$];
  int               mismatches   = 0;
  bit               steady_input = 1'b0;

  per_channel_replay_buffer_unit #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH),
    .SEQ_BITS (32)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** per_channel_replay_buffer_unit: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void clear_buffer_state();
    keep_limit = 7'(DEPTH);
    for (int c = 0; c < CHANNELS; c++) begin
      oldest[c]   = '0;
      fill[c]     = '0;
      chan_seq[c] = '0;
    end
  endfunction

  function automatic void predict_response(in_item_t c);
    out_item_t   r;
    logic [3:0]  ch;
    logic [5:0]  pos;
    logic [31:0] front;
    int          hits;
    int          k;
    ch     = c.channel;
    r      = '0;
    r.last = 1'b1;
    case (c.cmd)
      CMD_STORE: begin
        if (ch != 0 && c.reliable) begin
          // drop oldest entries until the fill is below the cap before appending
          while (fill[ch] > 0 && fill[ch] >= keep_limit) begin
            oldest[ch] = oldest[ch] + 6'd1;
            fill[ch]   = fill[ch] - 7'd1;
          end
          pos               = oldest[ch] + fill[ch][5:0];
          ring_seq[ch][pos] = c.seq_in;
          ring_pay[ch][pos] = c.payload_in;
          fill[ch]          = fill[ch] + 7'd1;
          if (c.seq_in >= chan_seq[ch]) chan_seq[ch] = c.seq_in;
        end
      end
      CMD_NEXT: begin
        chan_seq[ch] = chan_seq[ch] + 32'd1;
        r.issued_seq = chan_seq[ch];
        results_due = {results_due, r};
      end
      CMD_CLEAR: begin
        oldest[ch]   = '0;
        fill[ch]     = '0;
        chan_seq[ch] = '0;
      end
      default: begin
        if (fill[ch] == 0) begin
          r.replay_ok  = (c.acked_seq == 0);
          r.resync_req = (c.acked_seq != 0);
          results_due = {results_due, r};
        end else begin
          front = ring_seq[ch][oldest[ch]];
          if (front > 0 && c.acked_seq < front - 32'd1) begin
            r.resync_req = 1'b1;
            results_due = {results_due, r};
          end else begin
            hits = 0;
            for (int i = 0; i < fill[ch]; i++) begin
              pos = oldest[ch] + 6'(i);
              if (ring_seq[ch][pos] > c.acked_seq) hits++;
            end
            if (hits == 0) begin
              r.replay_ok = 1'b1;
              results_due = {results_due, r};
            end else begin
              k = 0;
              for (int i = 0; i < fill[ch]; i++) begin
                pos = oldest[ch] + 6'(i);
                if (ring_seq[ch][pos] > c.acked_seq) begin
                  k++;
                  r.entry_valid = 1'b1;
                  r.out_seq     = ring_seq[ch][pos];
                  r.out_payload = ring_pay[ch][pos];
                  r.last        = (k == hits);
                  r.replay_ok   = 1'b1;
                  results_due = {results_due, r};
                end
              end
            end
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = results_due[0];
        results_due.delete(0);
        if (out_data.entry_valid !== want.entry_valid)
          report_mismatch($sformatf("entry_valid got %b exp %b",
                                    out_data.entry_valid, want.entry_valid));
        if (out_data.out_seq !== want.out_seq)
          report_mismatch($sformatf("out_seq got %h exp %h",
                                    out_data.out_seq, want.out_seq));
        if (out_data.out_payload !== want.out_payload)
          report_mismatch($sformatf("out_payload got %h exp %h",
                                    out_data.out_payload, want.out_payload));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last got %b exp %b", out_data.last, want.last));
        if (out_data.replay_ok !== want.replay_ok)
          report_mismatch($sformatf("replay_ok got %b exp %b",
                                    out_data.replay_ok, want.replay_ok));
        if (out_data.resync_req !== want.resync_req)
          report_mismatch($sformatf("resync_req got %b exp %b",
                                    out_data.resync_req, want.resync_req));
        if (out_data.issued_seq !== want.issued_seq)
          report_mismatch($sformatf("issued_seq got %h exp %h",
                                    out_data.issued_seq, want.issued_seq));
      end
    end
  end

  // Result side back-pressure: mostly ready, short stalls, a few long ones
  initial begin : result_stall
    int run;
    int pick;
    run = 0;
    forever begin
      @(posedge clk);
      if (run > 0) begin
        run--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_ready <= 1'b1;
          run = $urandom_range(0, 12);
        end else if (pick < 62) begin
          out_ready <= 1'b1;
          run = $urandom_range(50, 150);
        end else if (pick < 93) begin
          out_ready <= 1'b0;
          run = $urandom_range(0, 2);
        end else begin
          out_ready <= 1'b0;
          run = $urandom_range(10, 40);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_input || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [3:0] ch, logic [31:0] seq,
                          logic [31:0] pay, logic rel, logic [31:0] ack);
    in_item_t item;
    int       gap;
    item.cmd        = op;
    item.channel    = ch;
    item.seq_in     = seq;
    item.payload_in = pay;
    item.reliable   = rel;
    item.acked_seq  = ack;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_response(item);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_cap(logic [CAP_W-1:0] v);
    wait_for_results();
    // stores and clears leave no result; let them retire
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    if (v != 0) keep_limit = (v > DEPTH) ? 7'(DEPTH) : v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_store_seq(logic [3:0] ch);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return chan_seq[ch] + $urandom_range(1, 3);
    if (r < 85) return chan_seq[ch] - $urandom_range(0, 5);
    if (r < 95) return $urandom;
    return (r < 97) ? 32'd0 : 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] pick_ack(logic [3:0] ch);
    logic [31:0] front;
    logic [31:0] newest;
    int          r;
    r = $urandom_range(0, 99);
    if (fill[ch] == 0) return (r < 50) ? 32'd0 : $urandom;
    front  = ring_seq[ch][oldest[ch]];
    newest = ring_seq[ch][oldest[ch] + 6'(fill[ch] - 7'd1)];
    if (r < 35) return front - 32'd1;
    if (r < 60) return front + $urandom_range(0, fill[ch]);
    if (r < 72) return newest;
    if (r < 85) return front - 32'd2 - $urandom_range(0, 4);
    if (r < 93) return 32'd0;
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_and_ignored();
    send_cmd(CMD_REPLAY, 4'd3, 32'd0, 32'd0, 1'b0, 32'd0);
    send_cmd(CMD_REPLAY, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // channel 0 and unreliable stores must leave the rings empty
    send_cmd(CMD_STORE, 4'd0, 32'd5, $urandom, 1'b1, 32'd0);
    send_cmd(CMD_REPLAY, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    send_cmd(CMD_STORE, 4'd5, 32'd9, $urandom, 1'b0, 32'd0);
    send_cmd(CMD_REPLAY, 4'd5, 32'd0, 32'd0, 1'b0, 32'd1);
  endtask

  task automatic test_replay_paths();
    send_cmd(CMD_STORE, 4'd5, 32'd10, $urandom, 1'b1, 32'd0);
    send_cmd(CMD_STORE, 4'd5, 32'd11, $urandom, 1'b1, 32'd0);
    send_cmd(CMD_STORE, 4'd5, 32'd12, $urandom, 1'b1, 32'd0);
    send_cmd(CMD_REPLAY, 4'd5, 32'd0, 32'd0, 1'b0, 32'd9);
    send_cmd(CMD_REPLAY, 4'd5, 32'd0, 32'd0, 1'b0, 32'd11);
    send_cmd(CMD_REPLAY, 4'd5, 32'd0, 32'd0, 1'b0, 32'd12);
    send_cmd(CMD_REPLAY, 4'd5, 32'd0, 32'd0, 1'b0, 32'd7);
    // oldest sequence zero never reports a gap
    send_cmd(CMD_STORE, 4'd7, 32'd0, $urandom, 1'b1, 32'd0);
    send_cmd(CMD_REPLAY, 4'd7, 32'd0, 32'd0, 1'b0, 32'd5);
  endtask

  task automatic test_counter_wrap();
    send_cmd(CMD_NEXT, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    send_cmd(CMD_NEXT, 4'd5, 32'd0, 32'd0, 1'b0, 32'd0);
    send_cmd(CMD_STORE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0);
    send_cmd(CMD_NEXT, 4'd15, 32'd0, 32'd0, 1'b0, 32'd0);
    wait_for_results();
    send_cmd(CMD_CLEAR, 4'd5, 32'd0, 32'd0, 1'b0, 32'd0);
    send_cmd(CMD_NEXT, 4'd5, 32'd0, 32'd0, 1'b0, 32'd0);
    send_cmd(CMD_REPLAY, 4'd5, 32'd0, 32'd0, 1'b0, 32'd0);
  endtask

  task automatic test_cap_limits();
    write_cap(7'd0);
    write_cap(7'd2);
    for (int s = 1; s <= 4; s++) send_cmd(CMD_STORE, 4'd9, 32'(s), $urandom, 1'b1, 32'd0);
    send_cmd(CMD_REPLAY, 4'd9, 32'd0, 32'd0, 1'b0, 32'd0);
    send_cmd(CMD_REPLAY, 4'd9, 32'd0, 32'd0, 1'b0, 32'd2);
    write_cap(7'd127);
    send_cmd(CMD_STORE, 4'd9, 32'd5, $urandom, 1'b1, 32'd0);
    write_cap(7'd1);
    // lowered cap only trims at the next store
    send_cmd(CMD_REPLAY, 4'd9, 32'd0, 32'd0, 1'b0, 32'd2);
    send_cmd(CMD_STORE, 4'd9, 32'd6, $urandom, 1'b1, 32'd0);
    send_cmd(CMD_REPLAY, 4'd9, 32'd0, 32'd0, 1'b0, 32'd5);
    send_cmd(CMD_REPLAY, 4'd9, 32'd0, 32'd0, 1'b0, 32'd0);
  endtask

  task automatic test_deep_ring();
    write_cap(7'd64);
    send_cmd(CMD_CLEAR, 4'd11, 32'd0, 32'd0, 1'b0, 32'd0);
    for (int s = 1; s <= 70; s++) send_cmd(CMD_STORE, 4'd11, 32'(s), $urandom, 1'b1, 32'd0);
    send_cmd(CMD_REPLAY, 4'd11, 32'd0, 32'd0, 1'b0, 32'd6);
    send_cmd(CMD_REPLAY, 4'd11, 32'd0, 32'd0, 1'b0, 32'd0);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [8];
    logic [3:0]       hot_a;
    logic [3:0]       hot_b;
    logic [3:0]       ch;
    int               k;
    caps = '{7'd1, 7'd3, 7'd64, 7'd17, 7'd2, 7'd127, 7'd40, 7'd64};
    for (int p = 0; p < 8; p++) begin
      write_cap(caps[p]);
      hot_a = 4'($urandom_range(1, 15));
      hot_b = 4'($urandom_range(0, 15));
      for (int n = 0; n < 32; n++) begin
        if ($urandom_range(0, 29) == 0) steady_input = !steady_input;
        if ($urandom_range(0, 49) == 0) wait_for_results();
        k = $urandom_range(0, 9);
        ch = (k < 4) ? hot_a : (k < 7) ? hot_b : 4'($urandom_range(0, 15));
        k = $urandom_range(0, 99);
        if (k < 8)
          send_cmd(2'($urandom), 4'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
        else if (k < 52)
          send_cmd(CMD_STORE, ch, pick_store_seq(ch), $urandom,
                   $urandom_range(0, 9) != 0, $urandom);
        else if (k < 82)
          send_cmd(CMD_REPLAY, ch, $urandom, $urandom, 1'($urandom), pick_ack(ch));
        else if (k < 96)
          send_cmd(CMD_NEXT, ch, $urandom, $urandom, 1'($urandom), $urandom);
        else
          send_cmd(CMD_CLEAR, ch, $urandom, $urandom, 1'($urandom), $urandom);
      end
    end
    steady_input = 1'b0;
  endtask

  initial begin : run_tests
    int idle;
    clear_buffer_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_ignored();
    test_replay_paths();
    test_counter_wrap();
    test_cap_limits();
    test_deep_ring();
    test_random_traffic();
    in_valid <= 1'b0;
    for (idle = 0; idle < DRAIN_LIMIT && results_due.size() != 0; idle++) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** per_channel_replay_buffer_unit: PASSED **");
    end else begin
      $display("** per_channel_replay_buffer_unit: FAILED **");
    end
    $finish;
  end

endmodule
